// ----- hw/rtl/tlca_pkg.sv -----
package tlca_pkg;

  localparam int NODES  = 1024;
  localparam int LEVELS = 10;

  localparam int NODE_W    = 10;
  localparam int DEPTH_W   = NODE_W;
  localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int LVL_CNT_W = $clog2(LEVELS + 1);
  localparam int JT_AW     = NODE_W + LVL_W;
  localparam int JT_DEPTH  = NODES * (2 ** LVL_W);
  localparam int NODE_MW   = DEPTH_W + 1;

  localparam int S_TDATA_W = ((2 * NODE_W + 7) / 8) * 8;
  localparam int RES_W     = NODE_W + 2;
  localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

  localparam logic CMD_ATTACH = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DUP_CHILD = 2'd1;
  localparam logic [1:0] ST_NO_PARENT = 2'd2;
  localparam logic [1:0] ST_NO_NODE   = 2'd3;

  typedef struct packed {
    logic               we;
    logic [NODE_W-1:0]  addr;
    logic [NODE_MW-1:0] data;
  } node_wr_t;

  typedef struct packed {
    logic              we;
    logic [JT_AW-1:0]  addr;
    logic [NODE_W-1:0] data;
  } jt_wr_t;

  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] anc;
    logic [1:0]        status;
  } result_t;

endpackage

// ----- hw/rtl/tlca_ram.sv -----
module tlca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/tlca_ctrl.sv -----
module tlca_ctrl
  import tlca_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic [NODE_W-1:0]  in_n1,
  input  logic [NODE_W-1:0]  in_n2,
  output node_wr_t           node_wr,
  output logic [NODE_W-1:0]  node_raddr,
  input  logic [NODE_MW-1:0] node_rdata,
  output jt_wr_t             jt_wr,
  output logic [JT_AW-1:0]   jt_raddr,
  input  logic [NODE_W-1:0]  jt_rdata,
  output result_t            res,
  input  logic               res_ready
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_RD1    = 4'd2;
  localparam logic [3:0] S_RD2    = 4'd3;
  localparam logic [3:0] S_CHK    = 4'd4;
  localparam logic [3:0] S_AFILL  = 4'd5;
  localparam logic [3:0] S_LIFT   = 4'd6;
  localparam logic [3:0] S_DESC_A = 4'd7;
  localparam logic [3:0] S_DESC_B = 4'd8;
  localparam logic [3:0] S_FINAL  = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  function automatic logic in_range(input logic [NODE_W-1:0] n);
    return (NODE_W+1)'(n) < (NODE_W+1)'(NODES);
  endfunction

  logic [3:0]           state;
  logic [NODE_W-1:0]    clr_cnt;
  logic                 cmd;
  logic [NODE_W-1:0]    n1, n2;
  logic                 p1;
  logic [DEPTH_W-1:0]   d1;
  logic [NODE_W-1:0]    a, b, ja;
  logic [LEVELS-1:0]    diff;
  logic [LVL_CNT_W-1:0] lv;
  logic                 pend;
  logic [NODE_W-1:0]    res_anc;
  logic [1:0]           res_st;

  logic [LVL_W-1:0]   lv_idx;
  logic               p2;
  logic [DEPTH_W-1:0] d2, d2_inc;
  logic               child_bad;
  logic               lv_end;
  logic [NODE_W-1:0]  a_cur, a_sel, b_sel;

  assign lv_idx    = lv[LVL_W-1:0];
  assign p2        = node_rdata[DEPTH_W] && in_range(n2);
  assign d2        = node_rdata[DEPTH_W-1:0];
  assign d2_inc    = (&d2) ? d2 : d2 + DEPTH_W'(1);
  assign child_bad = !in_range(n1) || p1;
  assign lv_end    = (lv == LVL_CNT_W'(LEVELS));
  // a lift read issued last cycle lands now
  assign a_cur     = pend ? jt_rdata : a;
  assign a_sel     = (ja != jt_rdata) ? ja : a;
  assign b_sel     = (ja != jt_rdata) ? jt_rdata : b;

  assign in_ready   = (state == S_IDLE);
  assign res.valid  = (state == S_DONE);
  assign res.anc    = res_anc;
  assign res.status = res_st;

  always_comb begin
    node_wr    = '0;
    node_raddr = n1;
    jt_wr      = '0;
    jt_raddr   = '0;
    case (state)
      S_CLEAR: begin
        node_wr.we   = 1'b1;
        node_wr.addr = clr_cnt;
        node_wr.data = (clr_cnt == '0) ? {1'b1, DEPTH_W'(0)} : '0;
        // root levels all point at the root
        if ((NODE_W+1)'(clr_cnt) < (NODE_W+1)'(LEVELS)) begin
          jt_wr.we   = 1'b1;
          jt_wr.addr = {NODE_W'(0), clr_cnt[LVL_W-1:0]};
          jt_wr.data = '0;
        end
      end
      S_RD2: begin
        node_raddr = n2;
      end
      S_CHK: begin
        if (cmd == CMD_ATTACH && !child_bad && p2) begin
          node_wr.we   = 1'b1;
          node_wr.addr = n1;
          node_wr.data = {1'b1, d2_inc};
          jt_wr.we     = 1'b1;
          jt_wr.addr   = {n1, LVL_W'(0)};
          jt_wr.data   = n2;
          jt_raddr     = {n2, LVL_W'(0)};
        end
      end
      S_AFILL: begin
        jt_wr.we   = 1'b1;
        jt_wr.addr = {n1, lv_idx};
        jt_wr.data = jt_rdata;
        jt_raddr   = {jt_rdata, lv_idx};
      end
      S_LIFT: begin
        if (!lv_end) begin
          jt_raddr = {a_cur, lv_idx};
        end else begin
          jt_raddr = {a_cur, LVL_W'(LEVELS - 1)};
        end
      end
      S_DESC_A: begin
        jt_raddr = {b, lv_idx};
      end
      S_DESC_B: begin
        if (lv == '0) begin
          jt_raddr = {a_sel, LVL_W'(0)};
        end else begin
          jt_raddr = {a_sel, lv_idx - LVL_W'(1)};
        end
      end
      default: begin
        node_raddr = n1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      lv      <= '0;
      pend    <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + NODE_W'(1);
          if (clr_cnt == NODE_W'(NODES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd   <= in_cmd;
            n1    <= in_n1;
            n2    <= in_n2;
            state <= S_RD1;
          end
        end
        S_RD1: begin
          state <= S_RD2;
        end
        S_RD2: begin
          p1    <= node_rdata[DEPTH_W] && in_range(n1);
          d1    <= node_rdata[DEPTH_W-1:0];
          state <= S_CHK;
        end
        S_CHK: begin
          res_anc <= '0;
          res_st  <= ST_OK;
          if (cmd == CMD_ATTACH) begin
            if (child_bad) begin
              res_st <= ST_DUP_CHILD;
              state  <= S_DONE;
            end else if (!p2) begin
              res_st <= ST_NO_PARENT;
              state  <= S_DONE;
            end else if (LEVELS == 1) begin
              state <= S_DONE;
            end else begin
              lv    <= LVL_CNT_W'(1);
              state <= S_AFILL;
            end
          end else if (!p1 || !p2) begin
            res_st <= ST_NO_NODE;
            state  <= S_DONE;
          end else begin
            // lift the deeper node
            if (d1 < d2) begin
              a    <= n2;
              b    <= n1;
              diff <= LEVELS'(d2 - d1);
            end else begin
              a    <= n1;
              b    <= n2;
              diff <= LEVELS'(d1 - d2);
            end
            lv    <= '0;
            pend  <= 1'b0;
            state <= S_LIFT;
          end
        end
        S_AFILL: begin
          if (lv == LVL_CNT_W'(LEVELS - 1)) begin
            state <= S_DONE;
          end else begin
            lv <= lv + LVL_CNT_W'(1);
          end
        end
        S_LIFT: begin
          a <= a_cur;
          if (lv_end) begin
            pend <= 1'b0;
            if (a_cur == b) begin
              res_anc <= a_cur;
              state   <= S_DONE;
            end else begin
              lv    <= LVL_CNT_W'(LEVELS - 1);
              state <= S_DESC_A;
            end
          end else begin
            pend <= diff[lv_idx];
            lv   <= lv + LVL_CNT_W'(1);
          end
        end
        S_DESC_A: begin
          ja    <= jt_rdata;
          state <= S_DESC_B;
        end
        S_DESC_B: begin
          a <= a_sel;
          b <= b_sel;
          if (lv == '0) begin
            state <= S_FINAL;
          end else begin
            lv    <= lv - LVL_CNT_W'(1);
            state <= S_DESC_A;
          end
        end
        S_FINAL: begin
          res_anc <= jt_rdata;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_RD1)
    else $error("accepted item did not start the node reads");

  a_root_kept: assert property (@(posedge clk) disable iff (rst)
    jt_wr.we && state != S_CLEAR |-> jt_wr.addr[JT_AW-1:LVL_W] != '0)
    else $error("root jump levels overwritten");

  a_fill_no_overlap: assert property (@(posedge clk) disable iff (rst)
    state == S_AFILL |-> jt_raddr != jt_wr.addr)
    else $error("jump table read and write hit the same entry");

  a_lv_bound: assert property (@(posedge clk) disable iff (rst)
    lv <= LVL_CNT_W'(LEVELS))
    else $error("level counter out of range");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status != ST_OK |-> res.anc == '0)
    else $error("error result with non-zero ancestor");

endmodule

// ----- hw/rtl/tree_lca_binary_lifting_top.sv -----
// Channel  Direction  tdata (low bit up)                 tuser
// s_*      in         first_node[9:0], second_node[19:10]  command (0 attach, 1 query)
// m_*      out        ancestor_node[9:0], status[11:10]    -
//
// After rst the node store is swept once, one entry a cycle, before s_tready
// first rises.
// Attach: node-store reads and checks, then the LEVELS - 1 upper jump-table levels
// are filled (one read and write a cycle), then the result.
// Query: node-store reads and checks, lift, descent (single read port), final read, result.
// One item is in flight at a time; a held m_* transfer stalls only the last step.
module tree_lca_binary_lifting_top
  import tlca_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // first_node, second_node, zero pad
  input  logic                 s_tuser,   // command
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata    // ancestor_node, status, zero pad
);

  node_wr_t           node_wr;
  logic [NODE_W-1:0]  node_raddr;
  logic [NODE_MW-1:0] node_rdata;
  jt_wr_t             jt_wr;
  logic [JT_AW-1:0]   jt_raddr;
  logic [NODE_W-1:0]  jt_rdata;
  result_t            res;
  logic               res_ready;
  logic [RES_W-1:0]   out_data;

  tlca_ram #(
    .WIDTH (NODE_MW),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_wr.we),
    .waddr (node_wr.addr),
    .wdata (node_wr.data),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  tlca_ram #(
    .WIDTH (NODE_W),
    .DEPTH (JT_DEPTH)
  ) u_jt_ram (
    .clk   (clk),
    .we    (jt_wr.we),
    .waddr (jt_wr.addr),
    .wdata (jt_wr.data),
    .raddr (jt_raddr),
    .rdata (jt_rdata)
  );

  tlca_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_cmd     (s_tuser),
    .in_n1      (s_tdata[NODE_W-1:0]),
    .in_n2      (s_tdata[2*NODE_W-1:NODE_W]),
    .node_wr    (node_wr),
    .node_raddr (node_raddr),
    .node_rdata (node_rdata),
    .jt_wr      (jt_wr),
    .jt_raddr   (jt_raddr),
    .jt_rdata   (jt_rdata),
    .res        (res),
    .res_ready  (res_ready)
  );

  // output register: take a new result once the old one has gone
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_data <= {res.status, res.anc};
    end
  end

  assign m_tdata = M_TDATA_W'(out_data);

endmodule

// ----- test/tree_lca_binary_lifting_top_test.sv -----
`timescale 1ns / 1ps

module tree_lca_binary_lifting_top_test
  import tlca_pkg::*;
;

  localparam int PHASE_ITEMS = 434;
  localparam int HOLD_AFTER  = 1100;  // results taken before the long hold-off
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 60;

  typedef struct {
    logic [NODE_W-1:0] anc;
    logic [1:0]        status;
  } lca_outcome_t;

  // Tree mirror: predicts the LCA and status of every accepted transfer.
  class lca_scoreboard;
    bit                present[NODES];
    logic [DEPTH_W-1:0] depth[NODES];
    logic [NODE_W-1:0] jump[NODES][LEVELS];
    logic [NODE_W-1:0] members[$];
    lca_outcome_t      outcomes[$];
    int mismatches, attaches, attach_rejects, queries, query_rejects, deepest;

    function new();
      present[0] = 1'b1;
      depth[0]   = '0;
      for (int lv = 0; lv < LEVELS; lv++) jump[0][lv] = '0;
      members.insert(members.size(), '0);
    endfunction

    function logic [NODE_W-1:0] newest();
      return members[members.size() - 1];
    endfunction

    function int pending();
      return outcomes.size();
    endfunction

    function logic [1:0] attach(logic [NODE_W-1:0] child, logic [NODE_W-1:0] parent);
      if (present[child]) return ST_DUP_CHILD;
      if (!present[parent]) return ST_NO_PARENT;
      depth[child] = (depth[parent] == '1) ? depth[parent] : depth[parent] + 1'b1;
      jump[child][0] = parent;
      for (int lv = 1; lv < LEVELS; lv++) jump[child][lv] = jump[jump[child][lv-1]][lv-1];
      present[child] = 1'b1;
      members.insert(members.size(), child);
      if (depth[child] > deepest) deepest = depth[child];
      return ST_OK;
    endfunction

    function logic [NODE_W-1:0] common_ancestor(logic [NODE_W-1:0] p, logic [NODE_W-1:0] q);
      logic [NODE_W-1:0]  x, y;
      logic [DEPTH_W-1:0] diff;
      x = p;
      y = q;
      if (depth[x] < depth[y]) begin
        x = q;
        y = p;
      end
      diff = depth[x] - depth[y];
      // lift the deeper node to the other's level
      for (int lv = 0; lv < LEVELS; lv++)
        if (diff[lv]) x = jump[x][lv];
      if (x == y) return x;
      for (int lv = LEVELS - 1; lv >= 0; lv--) begin
        if (jump[x][lv] != jump[y][lv]) begin
          x = jump[x][lv];
          y = jump[y][lv];
        end
      end
      return jump[x][0];
    endfunction

    function void note_transfer(logic cmd, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
      lca_outcome_t o;
      o.anc = '0;
      if (cmd == CMD_ATTACH) begin
        o.status = attach(a, b);
        attaches++;
        if (o.status != ST_OK) attach_rejects++;
      end else begin
        queries++;
        if (!present[a] || !present[b]) begin
          o.status = ST_NO_NODE;
          query_rejects++;
        end else begin
          o.status = ST_OK;
          o.anc    = common_ancestor(a, b);
        end
      end
      outcomes.insert(outcomes.size(), o);
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] data);
      lca_outcome_t      want;
      logic [NODE_W-1:0] got_anc;
      logic [1:0]        got_st;
      got_anc = data[NODE_W-1:0];
      got_st  = data[NODE_W +: 2];
      if (outcomes.size() == 0) begin
        report($sformatf("unexpected result anc=%0d status=%0d", got_anc, got_st));
        return;
      end
      want = outcomes.pop_front();
      if (got_anc !== want.anc || got_st !== want.status)
        report($sformatf("anc exp %0d got %0d, status exp %0d got %0d",
                         want.anc, got_anc, want.status, got_st));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tuser = CMD_ATTACH;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  int tx_idle_pct = 12;
  int rx_idle_pct = 88;

  lca_scoreboard sb = new();

  tree_lca_binary_lifting_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // Result sink: random back-pressure, plus one long hold-off so the block stalls its input.
  initial begin : result_sink
    int  hold_left;
    int  taken;
    bit  held;
    hold_left = 0;
    taken     = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) taken++;
      if (!held && taken >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_item(logic cmd, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= S_TDATA_W'({b, a});
    do @(posedge clk); while (!(s_tready && !rst));
    sb.note_transfer(cmd, a, b);
  endtask

  // Hold the input and wait for every outstanding result.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [NODE_W-1:0] pick_absent();
    logic [NODE_W-1:0] n;
    n = NODE_W'($urandom_range(NODES - 1));
    for (int i = 0; i < 32 && sb.present[n]; i++) n = NODE_W'($urandom_range(NODES - 1));
    return n;
  endfunction

  function automatic logic [NODE_W-1:0] pick_member();
    return sb.members[$urandom_range(sb.members.size() - 1)];
  endfunction

  task automatic random_item();
    logic              cmd;
    logic [NODE_W-1:0] a, b;
    int                r;
    r = $urandom_range(99);
    if (r < 55) begin
      // grow mostly along the newest branch so the tree gets deep
      cmd = CMD_ATTACH;
      a   = pick_absent();
      b   = ($urandom_range(99) < 80) ? sb.newest() : pick_member();
    end else if (r < 88) begin
      cmd = CMD_QUERY;
      a   = pick_member();
      b   = ($urandom_range(3) == 0) ? sb.newest() : pick_member();
    end else begin
      case ($urandom_range(3))
        0: begin
          cmd = CMD_ATTACH;
          a   = pick_member();
          b   = pick_member();
        end
        1: begin
          cmd = CMD_ATTACH;
          a   = pick_absent();
          b   = pick_absent();
        end
        2: begin
          cmd = CMD_QUERY;
          a   = pick_absent();
          b   = pick_member();
          if ($urandom_range(1)) begin
            b = a;
            a = pick_member();
          end
        end
        default: begin
          cmd = $urandom_range(1) ? CMD_QUERY : CMD_ATTACH;
          a   = NODE_W'($urandom_range(NODES - 1));
          b   = NODE_W'($urandom_range(NODES - 1));
        end
      endcase
    end
    send_item(cmd, a, b);
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // root as child, absent parent, child checked before parent
    send_item(CMD_ATTACH, 10'd0, 10'd0);
    send_item(CMD_ATTACH, 10'd1023, 10'd5);
    send_item(CMD_ATTACH, 10'd0, 10'd1023);
    send_item(CMD_QUERY, 10'd0, 10'd0);
    send_item(CMD_QUERY, 10'd0, 10'd1023);
    send_item(CMD_QUERY, 10'd1023, 10'd0);
    // two branches under 1023
    send_item(CMD_ATTACH, 10'd1023, 10'd0);
    send_item(CMD_ATTACH, 10'd512, 10'd1023);
    send_item(CMD_ATTACH, 10'd1, 10'd512);
    send_item(CMD_ATTACH, 10'd2, 10'd1023);
    send_item(CMD_ATTACH, 10'd3, 10'd2);
    send_item(CMD_QUERY, 10'd1, 10'd3);
    send_item(CMD_QUERY, 10'd3, 10'd1);
    send_item(CMD_QUERY, 10'd1, 10'd1);
    send_item(CMD_QUERY, 10'd1023, 10'd1);
    send_item(CMD_QUERY, 10'd1, 10'd0);
    send_item(CMD_QUERY, 10'd1023, 10'd1023);
    send_item(CMD_ATTACH, 10'd1, 10'd3);
    send_item(CMD_ATTACH, 10'd4, 10'd700);
    send_item(CMD_QUERY, 10'd4, 10'd1);
    send_item(CMD_QUERY, 10'd1, 10'd4);
    send_item(CMD_ATTACH, 10'd341, 10'd3);
    send_item(CMD_ATTACH, 10'd682, 10'd341);
    send_item(CMD_QUERY, 10'd682, 10'd512);

    for (int phase = 0; phase < 3; phase++) begin
      drain();
      tx_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 88 : 0;
      rx_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 12 : 0;
      for (int i = 0; i < PHASE_ITEMS; i++) random_item();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0) $display("%0d results never arrived", sb.pending());
    $display("Covered %0d attaches (%0d rejected) and %0d queries (%0d on absent nodes).",
             sb.attaches, sb.attach_rejects, sb.queries, sb.query_rejects);
    $display("Tree grew to %0d nodes, deepest at depth %0d; %0d mismatches.",
             sb.members.size(), sb.deepest, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** tree_lca_binary_lifting_top: PASSED **");
    end else begin
      $display("** tree_lca_binary_lifting_top: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("** tree_lca_binary_lifting_top: FAILED **");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/tlca_pkg.sv
hw/rtl/tlca_ram.sv
hw/rtl/tlca_ctrl.sv
hw/rtl/tree_lca_binary_lifting_top.sv
test/tree_lca_binary_lifting_top_test.sv
